// File: rtl/waypoint_steering_decider_assert.svh
// Assertion macros shared by the steering decider RTL.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef WAYPOINT_STEERING_DECIDER_ASSERT_SVH
`define WAYPOINT_STEERING_DECIDER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted
`define WSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted
`define WSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/wsd_pkg.sv
// Shared types and constants of the waypoint steering decider.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

	typedef enum logic [1:0] {
		ACT_ARRIVED,
		ACT_REVERSE,
		ACT_AVOID,
		ACT_DRIVE
	} action_t;

	typedef enum logic [1:0] {
		REG_ARRIVE_TOL,
		REG_BACKOFF,
		REG_AVOID
	} cfg_reg_t;

	localparam logic [15:0] ARRIVE_TOL_RST = 16'd77;
	localparam logic [15:0] BACKOFF_RST    = 16'd102;
	localparam logic [15:0] AVOID_RST      = 16'd205;

	localparam logic signed [4:0] SPEED_REVERSE = -5'sd5;
	localparam logic signed [4:0] SPEED_AVOID   = 5'sd5;
	localparam logic signed [4:0] SPEED_DRIVE   = 5'sd10;
	localparam logic signed [8:0] STEER_REVERSE = -9'sd10;
	localparam logic signed [8:0] STEER_AVOID   = 9'sd45;

	// Classified item passed from front to back
	typedef struct packed {
		action_t            act;
		logic               left;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [8:0]  hd;
	} wsd_item_t;

	// Fields carried alongside the CORDIC data
	typedef struct packed {
		action_t           act;
		logic              left;
		logic              zero;
		logic signed [8:0] hd;
	} wsd_side_t;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam int XW = 28;  // CORDIC x/y width: 25 bit input, gain and sqrt2 growth
	localparam int ZW = 34;  // angle accumulator, radians Q2.30 plus headroom

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sh0_6487_ED51;
	// Largest angle whose scaled value does not pass 180 degrees: floor(157*2^30/50)
	localparam logic signed [ZW-1:0] Z_HALF_TURN = 34'sd3371549327;

	// degrees = floor(|z| * 9000 / 2^30) / 157, the divide by reciprocal
	localparam logic [13:0] DEG_NUM   = 14'd9000;
	localparam logic [16:0] DIV157_M  = 17'd106862;  // ceil(2^24 / 157)
	localparam int          DIV157_SH = 24;

	function automatic logic [29:0] atan_q30(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:    v = 30'h3243F6A8;
			5'd1:    v = 30'h1DAC6705;
			5'd2:    v = 30'h0FADBAFC;
			5'd3:    v = 30'h07F56EA6;
			5'd4:    v = 30'h03FEAB76;
			5'd5:    v = 30'h01FFD55B;
			5'd6:    v = 30'h00FFFAAA;
			5'd7:    v = 30'h007FFF55;
			5'd8:    v = 30'h003FFFEA;
			5'd9:    v = 30'h001FFFFD;
			5'd10:   v = 30'h000FFFFF;
			5'd11:   v = 30'h0007FFFF;
			5'd12:   v = 30'h0003FFFF;
			5'd13:   v = 30'h0001FFFF;
			5'd14:   v = 30'h0000FFFF;
			5'd15:   v = 30'h00007FFF;
			5'd16:   v = 30'h00003FFF;
			5'd17:   v = 30'h00001FFF;
			5'd18:   v = 30'h00000FFF;
			5'd19:   v = 30'h000007FF;
			5'd20:   v = 30'h000003FF;
			5'd21:   v = 30'h000001FF;
			5'd22:   v = 30'h000000FF;
			5'd23:   v = 30'h0000007F;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/wsd_front.sv
// Front of the steering decider: configuration registers and item classification.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_front
	import wsd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic signed [15:0] current_x,
	input  wire logic signed [15:0] current_y,
	input  wire logic signed [8:0]  heading_deg,
	input  wire logic signed [15:0] target_x,
	input  wire logic signed [15:0] target_y,
	input  wire logic [15:0]        range_front,
	input  wire logic [15:0]        range_at_90,
	input  wire logic [15:0]        range_at_270,
	output wsd_item_t               item
);

	logic [15:0] tol_q;
	logic [15:0] backoff_q;
	logic [15:0] avoid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q     <= ARRIVE_TOL_RST;
			backoff_q <= BACKOFF_RST;
			avoid_q   <= AVOID_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ARRIVE_TOL: tol_q     <= cfg_data;
				REG_BACKOFF:    backoff_q <= cfg_data;
				REG_AVOID:      avoid_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [17:0] tol_e, cx_e, cy_e, tx_e, ty_e;
	logic               arrived;

	assign tol_e = signed'({2'b00, tol_q});
	assign cx_e  = 18'(current_x);
	assign cy_e  = 18'(current_y);
	assign tx_e  = 18'(target_x);
	assign ty_e  = 18'(target_y);

	// strictly inside the square around the target
	assign arrived = (cx_e > tx_e - tol_e) && (cx_e < tx_e + tol_e) &&
		(cy_e > ty_e - tol_e) && (cy_e < ty_e + tol_e);

	always_comb begin
		item.left = range_at_90 < range_at_270;
		item.dx   = 17'(target_x) - 17'(current_x);
		item.dy   = 17'(target_y) - 17'(current_y);
		item.hd   = heading_deg;
		priority if (arrived) begin
			item.act = ACT_ARRIVED;
		end else if (range_front < backoff_q) begin
			item.act = ACT_REVERSE;
		end else if (range_front < avoid_q) begin
			item.act = ACT_AVOID;
		end else begin
			item.act = ACT_DRIVE;
		end
	end

endmodule

`default_nettype wire

// File: rtl/wsd_queue.sv
// Short register queue between the front and back of the steering decider.
// Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_queue
	import wsd_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr,
	input  wire wsd_item_t wr_item,
	output logic           full,
	input  wire logic      rd,
	output wsd_item_t      rd_item,
	output logic           empty
);

	wsd_item_t          slot_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic               do_wr, do_rd;

	assign full    = cnt_q == QCNT_W'(QDEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`include "waypoint_steering_decider_assert.svh"

	`WSD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= QCNT_W'(QDEPTH))
	`WSD_ASSERT_NXT(a_cnt_up, do_wr && !do_rd, cnt_q == $past(cnt_q) + 1'b1)
	`WSD_ASSERT_NXT(a_ptr_gap, 1'b1, QPTR_W'(wr_ptr_q - rd_ptr_q) == QPTR_W'(cnt_q))

endmodule

`default_nettype wire

// File: rtl/wsd_back.sv
// Back of the steering decider: CORDIC bearing pipeline, degree scaling,
// angle wraps and the result register. Depends on wsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wsd_back
	import wsd_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire wsd_item_t        head,
	input  wire logic             q_empty,
	output logic                  q_pop,
	output logic                  empty,
	input  wire logic             pop,
	output logic [1:0]            action,
	output logic signed [4:0]     speed_tenths,
	output logic signed [8:0]     steer_deg
);

	localparam int N = CORDIC_STEPS;

	logic en;
	logic out_valid_q;

	// whole pipeline advances unless a finished result is held
	assign en    = !out_valid_q || pop;
	assign q_pop = en && !q_empty;
	assign empty = !out_valid_q;

	// the last step needs only the sign of y, so x stops one stage earlier
	logic signed [XW-1:0] x_s [0:N-2];
	logic signed [XW-1:0] y_s [0:N-1];
	logic signed [ZW-1:0] z_s [0:N];
	wsd_side_t            sb_s [0:N];
	logic [N:0]           vld_s;

	// pre-rotation of the left half plane
	logic signed [XW-1:0] xin, yin, x0, y0;
	logic signed [ZW-1:0] z0;

	assign xin = XW'(head.dx) <<< 8;
	assign yin = XW'(head.dy) <<< 8;

	always_comb begin
		if (xin[XW-1]) begin
			if (!yin[XW-1]) begin
				x0 = yin;
				y0 = -xin;
				z0 = HALF_PI_Q30;
			end else begin
				x0 = -yin;
				y0 = xin;
				z0 = -HALF_PI_Q30;
			end
		end else begin
			x0 = xin;
			y0 = yin;
			z0 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]       <= x0;
			y_s[0]       <= y0;
			z_s[0]       <= z0;
			sb_s[0].act  <= head.act;
			sb_s[0].left <= head.left;
			sb_s[0].zero <= (head.dx == '0) && (head.dy == '0);
			sb_s[0].hd   <= head.hd;
			for (int k = 1; k <= N; k++) begin
				sb_s[k] <= sb_s[k-1];
			end
			// one vectoring step per stage, rotate clockwise while y is not negative
			for (int k = 0; k < N - 2; k++) begin
				if (!y_s[k][XW-1]) begin
					x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				end else begin
					x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				end
			end
			for (int k = 0; k < N - 1; k++) begin
				if (!y_s[k][XW-1]) begin
					y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				end else begin
					y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				end
			end
			for (int k = 0; k < N; k++) begin
				if (!y_s[k][XW-1]) begin
					z_s[k+1] <= z_s[k] + signed'(ZW'(atan_q30(5'(k))));
				end else begin
					z_s[k+1] <= z_s[k] - signed'(ZW'(atan_q30(5'(k))));
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[N-1:0], !q_empty};
		end
	end

	// scale radians to degrees: multiply stage, then divide by 157 by reciprocal
	logic [ZW-2:0]        z_abs;
	logic [ZW+12:0]       prod_m;
	logic [16:0]          n_sm;
	logic                 neg_sm, over_sm, vld_sm;
	wsd_side_t            sb_sm;
	logic [33:0]          prod_q;
	logic [7:0]           q_sq;
	logic                 neg_sq, over_sq, vld_sq;
	wsd_side_t            sb_sq;

	assign z_abs  = z_s[N][ZW-1] ? (ZW-1)'(-z_s[N]) : (ZW-1)'(z_s[N]);
	assign prod_m = (ZW+13)'(z_abs) * (ZW+13)'(DEG_NUM);
	assign prod_q = 34'(n_sm) * 34'(DIV157_M);

	always_ff @(posedge clk) begin
		if (en) begin
			n_sm    <= prod_m[46:30];
			neg_sm  <= z_s[N][ZW-1];
			over_sm <= z_s[N] > Z_HALF_TURN;
			sb_sm   <= sb_s[N];
			q_sq    <= prod_q[DIV157_SH+7:DIV157_SH];
			neg_sq  <= neg_sm;
			over_sq <= over_sm;
			sb_sq   <= sb_sm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sm <= 1'b0;
			vld_sq <= 1'b0;
		end else if (en) begin
			vld_sm <= vld_s[N];
			vld_sq <= vld_sm;
		end
	end

	// truncate toward zero, wrap the bearing, subtract heading, wrap again
	logic signed [9:0]  t1, brg;
	logic signed [10:0] t2, t3;
	action_t            act_d;
	logic signed [4:0]  spd_d;
	logic signed [8:0]  steer_d;

	assign t1 = neg_sq ? -signed'({2'b00, q_sq}) : signed'({2'b00, q_sq});

	always_comb begin
		priority if (sb_sq.zero) begin
			brg = '0;
		end else if (t1 < -10'sd180) begin
			brg = t1 + 10'sd360;
		end else if (over_sq) begin
			brg = t1 - 10'sd360;
		end else begin
			brg = t1;
		end
		t2 = 11'(brg) - 11'(sb_sq.hd);
		priority if (t2 < -11'sd180) begin
			t3 = t2 + 11'sd360;
		end else if (t2 > 11'sd180) begin
			t3 = t2 - 11'sd360;
		end else begin
			t3 = t2;
		end
		act_d = sb_sq.act;
		unique case (sb_sq.act)
			ACT_ARRIVED: begin
				spd_d   = '0;
				steer_d = '0;
			end
			ACT_REVERSE: begin
				spd_d   = SPEED_REVERSE;
				steer_d = STEER_REVERSE;
			end
			ACT_AVOID: begin
				spd_d   = SPEED_AVOID;
				steer_d = sb_sq.left ? STEER_AVOID : -STEER_AVOID;
			end
			ACT_DRIVE: begin
				spd_d   = SPEED_DRIVE;
				steer_d = 9'(t3);
			end
			default: begin
				spd_d   = '0;
				steer_d = '0;
			end
		endcase
	end

	action_t act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_q        <= act_d;
			speed_tenths <= spd_d;
			steer_deg    <= steer_d;
		end
	end

	assign action = act_q;

	`include "waypoint_steering_decider_assert.svh"

	`WSD_ASSERT_IMP(a_bearing_range, vld_sq, (brg >= -10'sd180) && (brg <= 10'sd180))
	`WSD_ASSERT_IMP(a_arrived_still, out_valid_q && (act_q == ACT_ARRIVED),
		(speed_tenths == '0) && (steer_deg == '0))
	`WSD_ASSERT_IMP(a_drive_steer, out_valid_q && (act_q == ACT_DRIVE),
		(steer_deg >= -9'sd180) && (steer_deg <= 9'sd180))

endmodule

`default_nettype wire

// File: rtl/waypoint_steering_decider.sv
// Waypoint steering decider: one drive command per beat, classified in the front,
// bearing computed in a pipelined CORDIC back end, a four-entry queue in between.
// Throughput: one beat per cycle, one CORDIC stage per step; a held result stalls the back.
// Reset clears the registers to their defaults and drops every queued or in-flight beat.
// Depends on wsd_pkg, wsd_front, wsd_queue and wsd_back.
`timescale 1ns / 1ps
`default_nettype none

module waypoint_steering_decider
	import wsd_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [15:0] current_x,
	input  wire logic signed [15:0] current_y,
	input  wire logic signed [8:0]  heading_deg,
	input  wire logic signed [15:0] target_x,
	input  wire logic signed [15:0] target_y,
	input  wire logic [15:0]        range_front,
	input  wire logic [15:0]        range_at_90,
	input  wire logic [15:0]        range_at_270,
	output logic                    empty,
	input  wire logic               pop,
	output logic [1:0]              action,
	output logic signed [4:0]       speed_tenths,
	output logic signed [8:0]       steer_deg
);

	wsd_item_t front_item;
	wsd_item_t head_item;
	logic      q_empty;
	logic      q_pop;

	wsd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.current_x    (current_x),
		.current_y    (current_y),
		.heading_deg  (heading_deg),
		.target_x     (target_x),
		.target_y     (target_y),
		.range_front  (range_front),
		.range_at_90  (range_at_90),
		.range_at_270 (range_at_270),
		.item         (front_item)
	);

	wsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_item (front_item),
		.full    (full),
		.rd      (q_pop),
		.rd_item (head_item),
		.empty   (q_empty)
	);

	wsd_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head_item),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.empty        (empty),
		.pop          (pop),
		.action       (action),
		.speed_tenths (speed_tenths),
		.steer_deg    (steer_deg)
	);

endmodule

`default_nettype wire

// File: tb/tb_waypoint_steering_decider.sv
// Self-checking bench for waypoint_steering_decider: queued pose/range beats in,
// drive commands out, each checked against a bench-side bearing and decision predictor.
// Depends on wsd_pkg (action and register codes) and the waypoint_steering_decider RTL.
`timescale 1ns / 1ps

module tb_waypoint_steering_decider
	import wsd_pkg::*;
();

	localparam int          STEPS       = 16;
	localparam int          CYCLE_LIMIT = 500000;
	localparam int          TAIL_CYCLES = 40;
	localparam logic [1:0]  REG_UNUSED  = 2'd3;

	localparam longint QUARTER_TURN  = 64'sh6487ED51;
	localparam longint DEG_DIV       = 64'sd337154932736;  // 314 * 2^30
	localparam longint HALF_TURN_NUM = DEG_DIV * 180;
	localparam longint ATAN_Q30 [0:23] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	localparam logic signed [4:0] SPD_BACK  = -5'sd5;
	localparam logic signed [4:0] SPD_TURN  = 5'sd5;
	localparam logic signed [4:0] SPD_AHEAD = 5'sd10;
	localparam logic signed [8:0] STR_BACK  = -9'sd10;
	localparam logic signed [8:0] STR_TURN  = 9'sd45;

	typedef struct packed {
		logic signed [15:0] cur_x;
		logic signed [15:0] cur_y;
		logic signed [8:0]  heading;
		logic signed [15:0] tgt_x;
		logic signed [15:0] tgt_y;
		logic [15:0]        rng_front;
		logic [15:0]        rng_90;
		logic [15:0]        rng_270;
	} nav_item_t;

	typedef struct packed {
		action_t            act;
		logic signed [4:0]  speed;
		logic signed [8:0]  steer;
	} drive_cmd_t;

	logic               clk;
	logic               arst_n       = 1'b0;
	logic               cfg_we       = 1'b0;
	logic [1:0]         cfg_index    = '0;
	logic [15:0]        cfg_data     = '0;
	logic               push         = 1'b0;
	logic               full;
	logic signed [15:0] current_x    = '0;
	logic signed [15:0] current_y    = '0;
	logic signed [8:0]  heading_deg  = '0;
	logic signed [15:0] target_x     = '0;
	logic signed [15:0] target_y     = '0;
	logic [15:0]        range_front  = '0;
	logic [15:0]        range_at_90  = '0;
	logic [15:0]        range_at_270 = '0;
	logic               empty;
	logic               pop          = 1'b0;
	logic [1:0]         action;
	logic signed [4:0]  speed_tenths;
	logic signed [8:0]  steer_deg;

	// Register copies as the block should hold them
	logic [15:0] arrive_tol  = 16'd77;
	logic [15:0] backoff_lim = 16'd102;
	logic [15:0] avoid_lim   = 16'd205;

	nav_item_t  pending_items[$];
	drive_cmd_t expected_cmds[$];
	nav_item_t  on_ports;
	drive_cmd_t want;
	int         send_idle   = 0;
	int         recv_idle   = 0;
	int         mismatches  = 0;
	int         cycle_count = 0;
	bit         idling      = 1'b1;

	waypoint_steering_decider #(.CORDIC_STEPS(STEPS)) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full),
		.current_x(current_x), .current_y(current_y), .heading_deg(heading_deg),
		.target_x(target_x), .target_y(target_y),
		.range_front(range_front), .range_at_90(range_at_90), .range_at_270(range_at_270),
		.empty(empty), .pop(pop),
		.action(action), .speed_tenths(speed_tenths), .steer_deg(steer_deg)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint bearing_deg_of(input longint dx, input longint dy);
		longint x, y, z, ox, xs, ys, num, deg;
		int i;
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 256;
		y = dy * 256;
		z = 0;
		// fold the left half plane into the CORDIC range
		if (x < 0) begin
			ox = x;
			if (y >= 0) begin
				x = y;
				y = -ox;
				z = QUARTER_TURN;
			end else begin
				x = -y;
				y = ox;
				z = -QUARTER_TURN;
			end
		end
		for (i = 0; i < STEPS && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q30[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q30[i];
			end
		end
		num = z * 18000;
		deg = num / DEG_DIV;
		if (deg < -180)
			deg = deg + 360;
		else if (num > HALF_TURN_NUM)
			deg = deg - 360;
		return deg;
	endfunction

	function automatic drive_cmd_t decide_command(input nav_item_t it);
		drive_cmd_t c;
		longint cx, cy, tx, ty, tol, t;
		cx  = longint'(it.cur_x);
		cy  = longint'(it.cur_y);
		tx  = longint'(it.tgt_x);
		ty  = longint'(it.tgt_y);
		tol = longint'(arrive_tol);
		if (cx > tx - tol && cx < tx + tol && cy > ty - tol && cy < ty + tol) begin
			c.act   = ACT_ARRIVED;
			c.speed = '0;
			c.steer = '0;
		end else if (it.rng_front < backoff_lim) begin
			c.act   = ACT_REVERSE;
			c.speed = SPD_BACK;
			c.steer = STR_BACK;
		end else if (it.rng_front < avoid_lim) begin
			c.act   = ACT_AVOID;
			c.speed = SPD_TURN;
			c.steer = (it.rng_90 < it.rng_270) ? STR_TURN : -STR_TURN;
		end else begin
			t = bearing_deg_of(tx - cx, ty - cy) - longint'(it.heading);
			if (t < -180)
				t = t + 360;
			else if (t > 180)
				t = t - 360;
			c.act   = ACT_DRIVE;
			c.speed = SPD_AHEAD;
			c.steer = t[8:0];
		end
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < 100)
			$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Driver: hold the beat while full, idle in bursts between beats
	always @(posedge clk) begin
		if (push && !full)
			expected_cmds.push_back(decide_command(on_ports));
		if (!push || !full) begin
			if (!arst_n || pending_items.size() == 0) begin
				push <= 1'b0;
			end else if (send_idle > 0) begin
				push <= 1'b0;
				send_idle <= send_idle - 1;
			end else begin
				on_ports = pending_items.pop_front();
				current_x    <= on_ports.cur_x;
				current_y    <= on_ports.cur_y;
				heading_deg  <= on_ports.heading;
				target_x     <= on_ports.tgt_x;
				target_y     <= on_ports.tgt_y;
				range_front  <= on_ports.rng_front;
				range_at_90  <= on_ports.rng_90;
				range_at_270 <= on_ports.rng_270;
				push <= 1'b1;
				if (idling && $urandom_range(0, 7) == 0)
					send_idle <= $urandom_range(1, 10);
			end
		end
	end

	// Monitor: check each popped beat against the oldest expected command
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (expected_cmds.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected, action %0d", action));
			end else begin
				want = expected_cmds.pop_front();
				if (action !== want.act)
					report_mismatch($sformatf("action got %0d expected %0d",
						action, want.act));
				if (speed_tenths !== want.speed)
					report_mismatch($sformatf("speed_tenths got %0d expected %0d",
						speed_tenths, want.speed));
				if (steer_deg !== want.steer)
					report_mismatch($sformatf("steer_deg got %0d expected %0d",
						steer_deg, want.steer));
			end
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (recv_idle > 0) begin
			pop <= 1'b0;
			recv_idle <= recv_idle - 1;
		end else begin
			pop <= 1'b1;
			if (idling && $urandom_range(0, 7) == 0)
				recv_idle <= $urandom_range(1, 10);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [15:0] clamp_u16(input longint v);
		if (v < 0)
			return 16'd0;
		if (v > 65535)
			return 16'hFFFF;
		return v[15:0];
	endfunction

	function automatic logic [15:0] clamp_s16(input longint v);
		if (v < -32768)
			return 16'h8000;
		if (v > 32767)
			return 16'h7FFF;
		return v[15:0];
	endfunction

	task automatic add_item(input int cx, input int cy, input int hd, input int tx,
			input int ty, input int rf, input int r90, input int r270);
		nav_item_t it;
		it.cur_x     = cx[15:0];
		it.cur_y     = cy[15:0];
		it.heading   = hd[8:0];
		it.tgt_x     = tx[15:0];
		it.tgt_y     = ty[15:0];
		it.rng_front = rf[15:0];
		it.rng_90    = r90[15:0];
		it.rng_270   = r270[15:0];
		pending_items.push_back(it);
	endtask

	function automatic logic [15:0] pick_front_range();
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: return clamp_u16(longint'(backoff_lim) + longint'($urandom_range(0, 6)) - 3);
			2: return clamp_u16(longint'(avoid_lim) + longint'($urandom_range(0, 6)) - 3);
			3: return 16'($urandom_range(backoff_lim, avoid_lim));
			default: return 16'($urandom_range(avoid_lim, 16'hFFFF));
		endcase
	endfunction

	task automatic queue_random_items(input int count);
		nav_item_t it;
		longint span;
		int mode;
		repeat (count) begin
			it.cur_x = 16'($urandom);
			it.cur_y = 16'($urandom);
			mode = $urandom_range(0, 9);
			if (mode < 3)
				span = longint'(arrive_tol) + 4;
			else if (mode < 5)
				span = 2000;
			else
				span = 0;
			if (span == 0) begin
				it.tgt_x = 16'($urandom);
				it.tgt_y = 16'($urandom);
			end else begin
				if (span > 30000)
					span = 30000;
				it.tgt_x = clamp_s16(longint'(it.cur_x) +
					longint'($urandom_range(0, 32'(2 * span))) - span);
				it.tgt_y = clamp_s16(longint'(it.cur_y) +
					longint'($urandom_range(0, 32'(2 * span))) - span);
			end
			if ($urandom_range(0, 7) == 0)
				it.heading = 9'($urandom);
			else
				it.heading = 9'(int'($urandom_range(0, 360)) - 180);
			it.rng_front = pick_front_range();
			it.rng_90    = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 300)) :
				16'($urandom);
			it.rng_270   = ($urandom_range(0, 7) == 0) ? it.rng_90 : 16'($urandom);
			pending_items.push_back(it);
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || push || expected_cmds.size() != 0)
			@(posedge clk);
	endtask

	// Write all three limits back to back; when stray is set, a stray beat to the unused index goes first
	task automatic program_limits(input logic [15:0] tol, input logic [15:0] bo,
			input logic [15:0] av, input bit stray);
		if (stray) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_UNUSED;
			cfg_data  <= 16'($urandom);
			@(posedge clk);
		end
		cfg_we    <= 1'b1;
		cfg_index <= REG_ARRIVE_TOL;
		cfg_data  <= tol;
		@(posedge clk);
		cfg_index <= REG_BACKOFF;
		cfg_data  <= bo;
		@(posedge clk);
		cfg_index <= REG_AVOID;
		cfg_data  <= av;
		@(posedge clk);
		cfg_we <= 1'b0;
		arrive_tol  = tol;
		backoff_lim = bo;
		avoid_lim   = av;
	endtask

	initial begin
		int phase;
		logic [15:0] tol, bo, av;
		repeat (4) @(posedge clk);
		arrive_tol  = 16'd77;
		backoff_lim = 16'd102;
		avoid_lim   = 16'd205;
		arst_n <= 1'b1;
		@(posedge clk);

		// Default limits: arrival square edges, threshold edges, avoid sides, headings
		add_item(0, 0, 0, 0, 0, 0, 0, 0);
		add_item(76, 0, 0, 0, 0, 0, 0, 0);
		add_item(77, 0, 0, 0, 0, 0, 0, 0);
		add_item(0, -76, 0, 0, 0, 0, 0, 0);
		add_item(0, -77, 0, 0, 0, 101, 0, 0);
		add_item(-32768, 32767, -180, 32767, -32768, 65535, 65535, 65535);
		add_item(32767, -32768, 180, -32768, 32767, 65535, 0, 0);
		add_item(1000, 0, 0, 0, 0, 102, 0, 65535);
		add_item(1000, 0, 0, 0, 0, 204, 500, 500);
		add_item(1000, 0, 0, 0, 0, 150, 65535, 0);
		add_item(0, 0, 180, 1000, 0, 205, 0, 0);
		add_item(0, 0, -256, 1000, 1000, 205, 0, 0);
		add_item(0, 0, 255, -1000, 1000, 205, 0, 0);
		add_item(0, 0, -180, -1000, -1000, 205, 0, 0);
		add_item(0, 0, 90, 1000, -1000, 205, 0, 0);
		add_item(0, 0, 0, 0, 1000, 205, 0, 0);
		add_item(0, 0, 0, 0, -1000, 205, 0, 0);
		wait_drained();

		// Zero limits: no arrival, everything drives; zero offset and half-turn bearings
		program_limits(16'd0, 16'd0, 16'd0, 1'b1);
		add_item(100, -100, 90, 100, -100, 0, 0, 0);
		add_item(0, 0, 0, -256, 0, 0, 0, 0);
		add_item(0, 0, 0, -256, -1, 0, 0, 0);
		add_item(0, 0, -180, -32768, 0, 0, 0, 0);
		add_item(32767, 0, 180, -32768, 1, 65535, 0, 0);
		queue_random_items(170);
		wait_drained();

		// Saturated limits: nearly all arrive, otherwise reverse unless range is full scale
		program_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		add_item(-32768, -32768, 0, 32767, 32767, 65535, 0, 0);
		add_item(-32768, -32768, 0, 32767, 32767, 65534, 0, 0);
		queue_random_items(120);
		wait_drained();

		for (phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				idling = 1'b0;
			tol = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 800));
			bo  = 16'($urandom_range(0, 2000));
			av  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2000)) :
				16'(bo + $urandom_range(0, 4000));
			program_limits(tol, bo, av, phase[0]);
			queue_random_items(180);
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
